// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the ventilation control RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AHVC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ahvc assertion failed");
`define AHVC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("ahvc assertion failed");
`else
`define AHVC_ASSERT(lbl, clk, rstn, prop)
`define AHVC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/ahvc_pkg.sv =====
// Package of the absolute humidity vent control: register codes, constants,
// the configuration struct and the exponent table generator. No dependencies.
`default_nettype none
package ahvc_pkg;

    localparam logic [3:0] CFG_DRY_MARGIN   = 4'd0;
    localparam logic [3:0] CFG_FORCE_MARGIN = 4'd1;
    localparam logic [3:0] CFG_COLD_LIMIT   = 4'd2;
    localparam logic [3:0] CFG_WARM_LIMIT   = 4'd3;
    localparam logic [3:0] CFG_MAX_RUN      = 4'd4;
    localparam logic [3:0] CFG_RUN_WAIT     = 4'd5;
    localparam logic [3:0] CFG_IDLE_WAIT    = 4'd6;
    localparam logic [3:0] CFG_ERROR_WAIT   = 4'd7;

    localparam logic [63:0] LN2_Q30   = 64'd744261118;
    localparam logic [17:0] LOG2E_Q16 = 18'd94548;
    localparam logic [19:0] AH_K_Q8   = 20'd678254;
    localparam logic [14:0] AH_MAX    = 15'd32767;

    typedef struct packed {
        logic [12:0]        dry_margin;
        logic [12:0]        force_margin;
        logic signed [10:0] cold_limit;
        logic signed [10:0] warm_limit;
        logic [5:0]         max_run;
        logic [9:0]         run_wait;
        logic [9:0]         idle_wait;
        logic [9:0]         error_wait;
    } t_cfg;

    // Entry idx of the 2^frac table in Q30, from a 15 term Taylor series.
    function automatic logic [32:0] exp_entry(input int unsigned idx,
                                              input int unsigned bits);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        int unsigned k;
        z    = (64'(idx) * LN2_Q30) >> bits;
        term = 64'd1 << 30;
        sum  = term;
        for (k = 1; k <= 14; k++) begin
            term = ((term * z) >> 30) / 64'(k);
            sum  = sum + term;
        end
        return sum[32:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ahvc_if.sv =====
// Handshake interfaces of the vent control: reading input, result output
// and configuration write channel. No dependencies.
`default_nettype none
interface ahvc_in_if;
    logic               valid;
    logic               ready;
    logic [9:0]         indoor_rh;
    logic signed [10:0] indoor_temp;
    logic               indoor_valid;
    logic [9:0]         outdoor_rh;
    logic signed [10:0] outdoor_temp;
    logic               outdoor_valid;
    modport source (output valid, indoor_rh, indoor_temp, indoor_valid,
                    outdoor_rh, outdoor_temp, outdoor_valid, input ready);
    modport sink (input valid, indoor_rh, indoor_temp, indoor_valid,
                  outdoor_rh, outdoor_temp, outdoor_valid, output ready);
endinterface

interface ahvc_out_if;
    logic        valid;
    logic        ready;
    logic        fan_on;
    logic [9:0]  wait_seconds;
    logic [14:0] indoor_abs;
    logic [14:0] outdoor_abs;
    logic [5:0]  minutes_run;
    logic        sensor_fault;
    logic        last;
    modport source (output valid, fan_on, wait_seconds, indoor_abs, outdoor_abs,
                    minutes_run, sensor_fault, last, input ready);
    modport sink (input valid, fan_on, wait_seconds, indoor_abs, outdoor_abs,
                  minutes_run, sensor_fault, last, output ready);
endinterface

interface ahvc_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [12:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ahvc_lane.sv =====
// One absolute humidity lane: Magnus formula in fixed point with a shared
// bit-serial divider, table exponent and interpolation. Uses ahvc_pkg.
`default_nettype none
`include "assert_macros.svh"
module ahvc_lane
    import ahvc_pkg::*;
#(
    parameter int EXP_TABLE_BITS = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [9:0]         i_rh,
    input  wire logic signed [10:0] i_temp,
    output logic                    o_done,
    output logic [14:0]             o_abs
);

    localparam int TAB = (1 << EXP_TABLE_BITS) + 1;
    localparam int SH  = 16 - EXP_TABLE_BITS;
    localparam int PW  = 33 + SH;
    localparam logic [5:0] DIV_LAST = 6'd37;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIV1  = 4'd1;
    localparam logic [3:0] ST_PROD  = 4'd2;
    localparam logic [3:0] ST_TAB   = 4'd3;
    localparam logic [3:0] ST_INTP  = 4'd4;
    localparam logic [3:0] ST_SCALE = 4'd5;
    localparam logic [3:0] ST_SHIFT = 4'd6;
    localparam logic [3:0] ST_ROUND = 4'd7;
    localparam logic [3:0] ST_DIV2  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [32:0] w_tab [TAB];

    for (genvar g = 0; g < TAB; g++) begin : g_tab
        localparam logic [32:0] TV = exp_entry(g, EXP_TABLE_BITS);
        assign w_tab[g] = TV;
    end

    logic [3:0]         r_state;
    logic [5:0]         r_cnt;
    logic [37:0]        r_num;
    logic [19:0]        r_rem;
    logic [18:0]        r_den;
    logic               r_neg;
    logic [29:0]        r_krh;
    logic [13:0]        r_d2;
    logic signed [39:0] r_p;
    logic [32:0]        r_lo;
    logic [32:0]        r_dt;
    logic [SH-1:0]      r_rf;
    logic [32:0]        r_v;
    logic [56:0]        r_m;
    logic [63:0]        r_mx;
    logic [14:0]        r_abs;
    logic               r_done;

    logic [10:0]               w_mag;
    logic [11:0]               w_tp;
    logic [18:0]               w_d1;
    logic [13:0]               w_d2;
    logic [19:0]               w_rs;
    logic                      w_ge;
    logic [19:0]               w_rn;
    logic signed [21:0]        w_xq;
    logic [EXP_TABLE_BITS-1:0] w_idx;
    logic [EXP_TABLE_BITS:0]   w_ia;
    logic [EXP_TABLE_BITS:0]   w_ib;
    logic [PW-1:0]             w_ip;
    logic signed [8:0]         w_n;
    logic [8:0]                w_nmag;
    logic [64:0]               w_sum;

    always_comb begin
        w_mag  = i_temp[10] ? 11'(-i_temp) : 11'(i_temp);
        w_tp   = 12'($signed({{2{i_temp[10]}}, i_temp}) + 13'sd2435);
        w_d1   = 19'(w_tp * 7'd100);
        w_d2   = 14'($signed({{3{i_temp[10]}}, i_temp, 1'b0}) + 15'sd5463);
        w_rs   = {r_rem[18:0], r_num[37]};
        w_ge   = (w_rs >= {1'b0, r_den});
        w_rn   = w_ge ? (w_rs - {1'b0, r_den}) : w_rs;
        w_xq   = r_neg ? -$signed({1'b0, r_num[20:0]}) : $signed({1'b0, r_num[20:0]});
        w_idx  = r_p[31:32-EXP_TABLE_BITS];
        w_ia   = {1'b0, w_idx};
        w_ib   = w_ia + 1'b1;
        w_ip   = PW'(r_dt) * PW'(r_rf);
        w_n    = $signed({1'b0, r_p[39:32]}) - 9'sd32;
        w_nmag = 9'(-w_n);
        w_sum  = {1'b0, r_mx} + (65'(r_d2) << 31);
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_neg   <= i_temp[10];
                    r_num   <= {1'b0, 21'(w_mag * 11'd1767), 16'b0};
                    r_den   <= w_d1;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_krh   <= 30'(AH_K_Q8 * i_rh);
                    r_d2    <= w_d2;
                    r_state <= ST_DIV1;
                end
            end
            ST_DIV1, ST_DIV2: begin
                r_rem <= w_rn;
                r_num <= {r_num[36:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    r_state <= (r_state == ST_DIV1) ? ST_PROD : ST_OUT;
                end
            end
            ST_PROD: begin
                r_p     <= w_xq * $signed({1'b0, LOG2E_Q16}) + (40'sd1 <<< 37);
                r_state <= ST_TAB;
            end
            ST_TAB: begin
                r_lo    <= w_tab[w_ia];
                r_dt    <= w_tab[w_ib] - w_tab[w_ia];
                r_rf    <= r_p[16+SH-1:16];
                r_state <= ST_INTP;
            end
            ST_INTP: begin
                r_v     <= r_lo + 33'(w_ip >> SH);
                r_state <= ST_SCALE;
            end
            ST_SCALE: begin
                r_m     <= 57'(r_krh * r_v[32:6]);
                r_state <= ST_SHIFT;
            end
            ST_SHIFT: begin
                r_mx    <= w_n[8] ? ({7'b0, r_m} >> w_nmag) : ({7'b0, r_m} << $unsigned(w_n));
                r_state <= ST_ROUND;
            end
            ST_ROUND: begin
                r_num   <= {5'b0, w_sum[64:32]};
                r_den   <= {5'b0, r_d2};
                r_rem   <= '0;
                r_cnt   <= '0;
                r_state <= ST_DIV2;
            end
            ST_OUT: begin
                r_abs   <= (|r_num[37:15]) ? AH_MAX : r_num[14:0];
                r_done  <= 1'b1;
                r_state <= ST_IDLE;
            end
            default: begin
                r_state <= ST_IDLE;
            end
        endcase
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_abs  = r_abs;

    `AHVC_ASSERT(a_lane_cnt, i_clk, i_rst_n, (r_state == ST_DIV1 || r_state == ST_DIV2) |-> (r_cnt <= DIV_LAST))
    `AHVC_ASSERT(a_lane_start, i_clk, i_rst_n, i_start |-> (r_state == ST_IDLE))

endmodule
`default_nettype wire

// ===== rtl/core/ahvc_merge.sv =====
// Merging stage: combines both lane results into the vent decision, keeps
// the run counter and stages one or two results. Uses ahvc_pkg, ahvc_out_if.
`default_nettype none
`include "assert_macros.svh"
module ahvc_merge
    import ahvc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_done,
    input  wire logic [14:0]        i_ai,
    input  wire logic [14:0]        i_ao,
    input  wire logic               i_vi,
    input  wire logic               i_vo,
    input  wire logic signed [10:0] i_ti,
    input  wire logic signed [10:0] i_to,
    input  wire t_cfg               i_cfg,
    ahvc_out_if.source              o_out,
    output logic                    o_fin
);

    logic [5:0]  r_run;
    logic        r_have;
    logic        r_idx;
    logic        r_two;
    logic        r_fan;
    logic [9:0]  r_wait;
    logic [5:0]  r_mins;
    logic        r_fault;
    logic [14:0] r_ai;
    logic [14:0] r_ao;
    logic        r_ov;
    logic        r_o_fan;
    logic [9:0]  r_o_wait;
    logic [14:0] r_o_ai;
    logic [14:0] r_o_ao;
    logic [5:0]  r_o_mins;
    logic        r_o_fault;
    logic        r_o_last;

    logic [14:0]        w_ai;
    logic [14:0]        w_ao;
    logic signed [15:0] w_diff;
    logic               w_temp_ok;
    logic               w_vent;
    logic [5:0]         w_inc;
    logic               w_free;

    always_comb begin
        w_ai      = i_vi ? i_ai : '0;
        w_ao      = i_vo ? i_ao : '0;
        w_diff    = $signed({1'b0, w_ai}) - $signed({1'b0, w_ao});
        w_temp_ok = ((i_ti < i_cfg.cold_limit) && (i_to >= i_ti)) ||
                    ((i_ti > i_cfg.warm_limit) && (i_to <= i_ti)) ||
                    (w_diff > $signed({3'b0, i_cfg.force_margin}));
        w_vent    = (w_diff > $signed({3'b0, i_cfg.dry_margin})) && w_temp_ok;
        w_inc     = r_run + 1'b1;
        w_free    = !r_ov || o_out.ready;
        o_fin     = r_have && w_free && (!r_two || r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (i_done) begin
            r_have <= 1'b1;
            r_idx  <= 1'b0;
            r_ai   <= w_ai;
            r_ao   <= w_ao;
            if (!(i_vi && i_vo)) begin
                r_run   <= '0;
                r_two   <= 1'b0;
                r_fan   <= 1'b0;
                r_wait  <= i_cfg.error_wait;
                r_mins  <= '0;
                r_fault <= 1'b1;
            end else if (w_vent) begin
                r_two   <= (w_inc >= i_cfg.max_run);
                r_run   <= (w_inc >= i_cfg.max_run) ? '0 : w_inc;
                r_fan   <= 1'b1;
                r_wait  <= i_cfg.run_wait;
                r_mins  <= w_inc;
                r_fault <= 1'b0;
            end else begin
                r_two   <= 1'b0;
                r_fan   <= 1'b0;
                r_wait  <= i_cfg.idle_wait;
                r_mins  <= r_run;
                r_fault <= 1'b0;
            end
        end else if (r_have && w_free) begin
            if (!r_two || r_idx) begin
                r_have <= 1'b0;
            end
            r_idx <= 1'b1;
        end

        if (r_have && w_free) begin
            r_ov    <= 1'b1;
            r_o_ai  <= r_ai;
            r_o_ao  <= r_ao;
            if (r_idx) begin
                r_o_fan   <= 1'b0;
                r_o_wait  <= i_cfg.idle_wait;
                r_o_mins  <= '0;
                r_o_fault <= 1'b0;
                r_o_last  <= 1'b1;
            end else begin
                r_o_fan   <= r_fan;
                r_o_wait  <= r_wait;
                r_o_mins  <= r_mins;
                r_o_fault <= r_fault;
                r_o_last  <= !r_two;
            end
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end

        if (!i_rst_n) begin
            r_run  <= '0;
            r_have <= 1'b0;
            r_idx  <= 1'b0;
            r_ov   <= 1'b0;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.fan_on       = r_o_fan;
    assign o_out.wait_seconds = r_o_wait;
    assign o_out.indoor_abs   = r_o_ai;
    assign o_out.outdoor_abs  = r_o_ao;
    assign o_out.minutes_run  = r_o_mins;
    assign o_out.sensor_fault = r_o_fault;
    assign o_out.last         = r_o_last;

    `AHVC_ASSERT(a_merge_done_free, i_clk, i_rst_n, i_done |-> !r_have)
    `AHVC_ASSERT(a_merge_second, i_clk, i_rst_n, (r_have && r_idx) |-> r_two)
    `AHVC_ASSERT(a_merge_fault_clear, i_clk, i_rst_n, (i_done && !(i_vi && i_vo)) |=> (r_run == 6'd0))

endmodule
`default_nettype wire

// ===== rtl/core/absolute_humidity_vent_control.sv =====
// Top level of the absolute humidity vent control: configuration registers,
// input capture, two humidity lanes and the merging stage.
// Depends on ahvc_pkg, ahvc_if, ahvc_lane and ahvc_merge.
//
//   Channel  Direction  Carries
//   i_in     in         one reading pair, indoor and outdoor, with valid flags
//   o_out    out        fan state, wait, both humidities, run count, fault, last
//   i_cfg    in         register index and write data, always ready
//
// Each lane runs two 38 step bit-serial divisions, with the product,
// table, interpolation, scale, shift and round steps between them. The
// next item is taken once the final result of the current one sits in
// the output register. Reset is synchronous, restores the configuration
// defaults and the control state and clears the run counter. A stalled
// output holds the result and the pending second result, losing neither.
`default_nettype none
`include "assert_macros.svh"
module absolute_humidity_vent_control
    import ahvc_pkg::*;
#(
    parameter int EXP_TABLE_BITS = 6
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ahvc_in_if.sink    i_in,
    ahvc_out_if.source o_out,
    ahvc_cfg_if.sink   i_cfg
);

    t_cfg               r_cfg;
    logic               r_busy;
    logic               r_vi;
    logic               r_vo;
    logic signed [10:0] r_ti;
    logic signed [10:0] r_to;

    logic        w_acc;
    logic        w_done_i;
    logic        w_done_o;
    logic [14:0] w_ai;
    logic [14:0] w_ao;
    logic        w_fin;

    assign w_acc       = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_busy;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DRY_MARGIN:   r_cfg.dry_margin   <= i_cfg.data;
                CFG_FORCE_MARGIN: r_cfg.force_margin <= i_cfg.data;
                CFG_COLD_LIMIT:   r_cfg.cold_limit   <= i_cfg.data[10:0];
                CFG_WARM_LIMIT:   r_cfg.warm_limit   <= i_cfg.data[10:0];
                CFG_MAX_RUN:      r_cfg.max_run      <= i_cfg.data[5:0];
                CFG_RUN_WAIT:     r_cfg.run_wait     <= i_cfg.data[9:0];
                CFG_IDLE_WAIT:    r_cfg.idle_wait    <= i_cfg.data[9:0];
                CFG_ERROR_WAIT:   r_cfg.error_wait   <= i_cfg.data[9:0];
                default: begin
                end
            endcase
        end
        if (w_acc) begin
            r_busy <= 1'b1;
            r_vi   <= i_in.indoor_valid;
            r_vo   <= i_in.outdoor_valid;
            r_ti   <= i_in.indoor_temp;
            r_to   <= i_in.outdoor_temp;
        end else if (w_fin) begin
            r_busy <= 1'b0;
        end
        if (!i_rst_n) begin
            r_busy             <= 1'b0;
            r_cfg.dry_margin   <= 13'd350;
            r_cfg.force_margin <= 13'd1000;
            r_cfg.cold_limit   <= 11'sd50;
            r_cfg.warm_limit   <= 11'sd200;
            r_cfg.max_run      <= 6'd60;
            r_cfg.run_wait     <= 10'd60;
            r_cfg.idle_wait    <= 10'd600;
            r_cfg.error_wait   <= 10'd70;
        end
    end

    ahvc_lane #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_lane_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc),
        .i_rh    (i_in.indoor_rh),
        .i_temp  (i_in.indoor_temp),
        .o_done  (w_done_i),
        .o_abs   (w_ai)
    );

    ahvc_lane #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_lane_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc),
        .i_rh    (i_in.outdoor_rh),
        .i_temp  (i_in.outdoor_temp),
        .o_done  (w_done_o),
        .o_abs   (w_ao)
    );

    ahvc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_done  (w_done_i),
        .i_ai    (w_ai),
        .i_ao    (w_ao),
        .i_vi    (r_vi),
        .i_vo    (r_vo),
        .i_ti    (r_ti),
        .i_to    (r_to),
        .i_cfg   (r_cfg),
        .o_out   (o_out),
        .o_fin   (w_fin)
    );

    `AHVC_ASSERT(a_top_lanes_sync, i_clk, i_rst_n, w_done_i == w_done_o)

endmodule
`default_nettype wire
